// ----- hdl/cltok_pkg.sv -----
// Shared types, constants and helpers for the command line tokenizer.
package cltok_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int MAX_TOKEN_SLOTS     = 64;
   localparam int MAX_RESULTS         = 3;
   localparam int CSR_INDEX_WIDTH     = 2;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam logic [7:0] BYTE_LIMIT_RESET  = 8'd255;
   localparam logic [6:0] COUNT_LIMIT_RESET = 7'd64;
   localparam logic [6:0] COUNT_CAP         = 7'(MAX_TOKEN_SLOTS);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BYTE_LIMIT  = 2'd0,
      CSR_COUNT_LIMIT = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_BETWEEN = 2'd0,
      MODE_PLAIN   = 2'd1,
      MODE_QUOTED  = 2'd2
   } scan_mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE      = 2'd0,
      KIND_TOKEN_END = 2'd1,
      KIND_LINE_END  = 2'd2
   } result_kind_type;

   typedef enum logic [1:0] {
      OP_NONE      = 2'd0,
      OP_ADD       = 2'd1,
      OP_END_TOKEN = 2'd2,
      OP_END_LINE  = 2'd3
   } op_type;

   typedef struct packed {
      result_kind_type kind;
      logic [7:0]      data_byte;
      logic [5:0]      token_number;
      logic [7:0]      token_length;
      logic            length_cut;
      logic [6:0]      token_total;
      logic            count_cut;
   } result_type;

   typedef struct packed {
      logic [1:0]                       count;
      result_type [MAX_RESULTS-1:0]     slot;
   } bundle_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

endpackage

// ----- hdl/cltok_front.sv -----
// Front end: accept line bytes, scan them and build the result bundle of each byte.
module cltok_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_line_byte,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cltok_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [7:0]                             csr_data,
   input  logic                                   queue_full,
   output logic                                   push,
   output cltok_pkg::bundle_type                  push_bundle
);
   import cltok_pkg::*;

   scan_mode_type mode_ff, mode_in, mode_dec;
   logic          quote_double_ff, quote_double_in, quote_double_dec;
   logic          bs_pending_ff, bs_pending_in, bs_pending_dec;
   logic          line_over_ff, line_over_in, line_over_dec;
   logic [6:0]    tokens_done_ff, tokens_done_in;
   logic [7:0]    bytes_in_token_ff, bytes_in_token_in;
   logic          token_over_ff, token_over_in;
   logic [7:0]    byte_limit_ff;
   logic [6:0]    count_limit_ff;

   op_type        op_kind [MAX_RESULTS];
   logic [7:0]    op_byte [MAX_RESULTS];
   logic [7:0]    closing_quote;
   logic [6:0]    count_eff;
   logic          accept;
   bundle_type    bundle;

   assign accept    = req_valid && !queue_full;
   assign req_stall = queue_full;
   assign csr_ready = 1'b1;
   assign closing_quote = quote_double_ff ? CH_DQUOTE : CH_SQUOTE;
   assign count_eff  = (count_limit_ff > COUNT_CAP) ? COUNT_CAP : count_limit_ff;

   // classify the byte into a short list of operations
   always_comb begin
      logic [7:0] b;
      b = req_line_byte;
      mode_dec         = mode_ff;
      quote_double_dec = quote_double_ff;
      bs_pending_dec   = bs_pending_ff;
      line_over_dec    = line_over_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         op_kind[i] = OP_NONE;
         op_byte[i] = b;
      end
      unique case (mode_ff)
         MODE_PLAIN: begin
            if (bs_pending_ff) begin
               bs_pending_dec = 1'b0;
               if (b == CH_NUL) begin
                  op_kind[0] = OP_ADD;
                  op_byte[0] = CH_BSLASH;
                  op_kind[1] = OP_END_TOKEN;
                  op_kind[2] = OP_END_LINE;
               end else begin
                  op_kind[0] = OP_ADD;
               end
            end else if (b == CH_NUL) begin
               op_kind[0] = OP_END_TOKEN;
               op_kind[1] = OP_END_LINE;
            end else if (is_ws(b)) begin
               op_kind[0] = OP_END_TOKEN;
            end else if (b == CH_BSLASH) begin
               bs_pending_dec = 1'b1;
            end else begin
               op_kind[0] = OP_ADD;
            end
         end
         MODE_QUOTED: begin
            if (bs_pending_ff) begin
               bs_pending_dec = 1'b0;
               if (b == closing_quote || b == CH_BSLASH) begin
                  op_kind[0] = OP_ADD;
               end else if (b == CH_NUL) begin
                  op_kind[0] = OP_ADD;
                  op_byte[0] = CH_BSLASH;
                  op_kind[1] = OP_END_TOKEN;
                  op_kind[2] = OP_END_LINE;
               end else begin
                  op_kind[0] = OP_ADD;
                  op_byte[0] = CH_BSLASH;
                  op_kind[1] = OP_ADD;
               end
            end else if (b == CH_NUL) begin
               op_kind[0] = OP_END_TOKEN;
               op_kind[1] = OP_END_LINE;
            end else if (b == closing_quote) begin
               op_kind[0] = OP_END_TOKEN;
            end else if (b == CH_BSLASH) begin
               bs_pending_dec = 1'b1;
            end else begin
               op_kind[0] = OP_ADD;
            end
         end
         default: begin
            mode_dec = MODE_BETWEEN;
            if (b == CH_NUL) begin
               op_kind[0] = OP_END_LINE;
            end else if (is_ws(b)) begin
               mode_dec = MODE_BETWEEN;
            end else if (tokens_done_ff >= count_eff) begin
               line_over_dec = 1'b1;
            end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
               mode_dec         = MODE_QUOTED;
               quote_double_dec = (b == CH_DQUOTE);
            end else begin
               mode_dec = MODE_PLAIN;
               if (b == CH_BSLASH) begin
                  bs_pending_dec = 1'b1;
               end else begin
                  op_kind[0] = OP_ADD;
               end
            end
         end
      endcase
   end

   // apply the operations in order: next state and emitted results
   always_comb begin
      logic [1:0] n;
      n                 = 2'd0;
      bundle            = '0;
      mode_in           = mode_dec;
      quote_double_in   = quote_double_dec;
      bs_pending_in     = bs_pending_dec;
      line_over_in      = line_over_dec;
      tokens_done_in    = tokens_done_ff;
      bytes_in_token_in = bytes_in_token_ff;
      token_over_in     = token_over_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         unique case (op_kind[i])
            OP_ADD: begin
               if (bytes_in_token_in < byte_limit_ff) begin
                  bundle.slot[n].kind         = KIND_BYTE;
                  bundle.slot[n].data_byte    = op_byte[i];
                  bundle.slot[n].token_number = tokens_done_in[5:0];
                  n                 = n + 2'd1;
                  bytes_in_token_in = bytes_in_token_in + 8'd1;
               end else begin
                  token_over_in = 1'b1;
               end
            end
            OP_END_TOKEN: begin
               bundle.slot[n].kind         = KIND_TOKEN_END;
               bundle.slot[n].token_number = tokens_done_in[5:0];
               bundle.slot[n].token_length = bytes_in_token_in;
               bundle.slot[n].length_cut   = token_over_in;
               n                 = n + 2'd1;
               tokens_done_in    = tokens_done_in + 7'd1;
               bytes_in_token_in = 8'd0;
               token_over_in     = 1'b0;
               bs_pending_in     = 1'b0;
               quote_double_in   = 1'b0;
               mode_in           = MODE_BETWEEN;
            end
            OP_END_LINE: begin
               bundle.slot[n].kind        = KIND_LINE_END;
               bundle.slot[n].token_total = tokens_done_in;
               bundle.slot[n].count_cut   = line_over_in;
               n                 = n + 2'd1;
               tokens_done_in    = 7'd0;
               bytes_in_token_in = 8'd0;
               token_over_in     = 1'b0;
               bs_pending_in     = 1'b0;
               quote_double_in   = 1'b0;
               line_over_in      = 1'b0;
               mode_in           = MODE_BETWEEN;
            end
            default: begin
               n = n;
            end
         endcase
      end
      bundle.count = n;
   end

   assign push        = accept && (bundle.count != 2'd0);
   assign push_bundle = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_BETWEEN;
         quote_double_ff   <= 1'b0;
         bs_pending_ff     <= 1'b0;
         line_over_ff      <= 1'b0;
         tokens_done_ff    <= 7'd0;
         bytes_in_token_ff <= 8'd0;
         token_over_ff     <= 1'b0;
      end else if (accept) begin
         mode_ff           <= mode_in;
         quote_double_ff   <= quote_double_in;
         bs_pending_ff     <= bs_pending_in;
         line_over_ff      <= line_over_in;
         tokens_done_ff    <= tokens_done_in;
         bytes_in_token_ff <= bytes_in_token_in;
         token_over_ff     <= token_over_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_limit_ff  <= BYTE_LIMIT_RESET;
         count_limit_ff <= COUNT_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BYTE_LIMIT:  byte_limit_ff  <= csr_data;
            CSR_COUNT_LIMIT: count_limit_ff <= csr_data[6:0];
            default:         byte_limit_ff  <= byte_limit_ff;
         endcase
      end
   end

endmodule

// ----- hdl/cltok_queue.sv -----
// Bundle queue between the scanning front end and the result serialiser.
module cltok_queue #(
   parameter int DEPTH = cltok_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cltok_pkg::bundle_type push_bundle,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output cltok_pkg::bundle_type head
);
   import cltok_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type    store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_bundle;
      end
   end

`ifndef ASSERT_OFF
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue pushed while full");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("queue count failed to rise");
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> head.count != 2'd0)
      else $error("queue holds an empty bundle");
`endif

endmodule

// ----- hdl/cltok_back.sv -----
// Back end: unload bundles one result at a time into the response register.
module cltok_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  cltok_pkg::bundle_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_result_kind,
   output logic [7:0]            rsp_data_byte,
   output logic [5:0]            rsp_token_number,
   output logic [7:0]            rsp_token_length,
   output logic                  rsp_length_cut,
   output logic [6:0]            rsp_token_total,
   output logic                  rsp_count_cut,
   output logic                  rsp_last_of_run
);
   import cltok_pkg::*;

   logic [1:0] slot_ff, slot_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       rsp_last_ff;
   logic       load;
   logic       last;

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign last = (slot_ff == (head.count - 2'd1));
   assign pop  = load && last;

   always_comb begin
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         slot_in      = last ? 2'd0 : slot_ff + 2'd1;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff      <= head.slot[slot_ff];
         rsp_last_ff <= last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_ff.kind;
   assign rsp_data_byte    = rsp_ff.data_byte;
   assign rsp_token_number = rsp_ff.token_number;
   assign rsp_token_length = rsp_ff.token_length;
   assign rsp_length_cut   = rsp_ff.length_cut;
   assign rsp_token_total  = rsp_ff.token_total;
   assign rsp_count_cut    = rsp_ff.count_cut;
   assign rsp_last_of_run  = rsp_last_ff;

endmodule

// ----- hdl/command_line_tokenizer_core.sv -----
// Top level of the command line tokenizer: front end, bundle queue and serialiser.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   req_line_byte
//   rsp_      out        rsp_valid / rsp_stall   kind, byte, token number, length, flags
//   csr_      in         csr_valid / csr_ready   csr_index, csr_data
//
// One request is taken per cycle while the bundle queue has room.
// Each request yields zero to three results; results leave one per cycle while rsp_stall
// is low, so runs of multi-result requests fill the queue (QUEUE_DEPTH bundles) and
// raise req_stall until the serialiser catches up.
// Synchronous reset clears the scan state and restores both limits; no clearing pass.
module command_line_tokenizer_core #(
   parameter int QUEUE_DEPTH = cltok_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_line_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_result_kind,
   output logic [7:0]                             rsp_data_byte,
   output logic [5:0]                             rsp_token_number,
   output logic [7:0]                             rsp_token_length,
   output logic                                   rsp_length_cut,
   output logic [6:0]                             rsp_token_total,
   output logic                                   rsp_count_cut,
   output logic                                   rsp_last_of_run,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cltok_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [7:0]                             csr_data
);
   import cltok_pkg::*;

   logic       queue_full;
   logic       push;
   bundle_type push_bundle;
   logic       pop;
   logic       head_valid;
   bundle_type head;

   cltok_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_line_byte (req_line_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .queue_full    (queue_full),
      .push          (push),
      .push_bundle   (push_bundle)
   );

   cltok_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .full        (queue_full),
      .pop         (pop),
      .head_valid  (head_valid),
      .head        (head)
   );

   cltok_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_token_number (rsp_token_number),
      .rsp_token_length (rsp_token_length),
      .rsp_length_cut   (rsp_length_cut),
      .rsp_token_total  (rsp_token_total),
      .rsp_count_cut    (rsp_count_cut),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
